// File: src/pid_speed_step_assert.svh
// Assertion macros shared by the checker of the speed loop controller.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef PID_SPEED_STEP_ASSERT_SVH
`define PID_SPEED_STEP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/pss_pkg.sv
package pss_pkg;

    // Field widths.
    localparam int SPEED_W  = 16;
    localparam int GAIN_W   = 16;
    localparam int LIMIT_W  = 23;
    localparam int DRIVE_W  = 13;
    localparam int ERR_W    = SPEED_W + 1;
    localparam int DERR_W   = ERR_W + 1;

    // Controller constants.
    localparam int OUT_LIMIT  = 4000;
    localparam int SUM_WIDTH  = 24;
    localparam int DRIVE_SHIFT = 8;

    // Working width for the clamped sum: must hold sum plus error and +/- limit.
    localparam int CLAMP_W = (SUM_WIDTH + 1 > LIMIT_W + 1) ? SUM_WIDTH + 1 : LIMIT_W + 1;

    // Product and accumulation widths (gains are zero-extended to signed).
    localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
    localparam int PROD_I_W = GAIN_W + 1 + SUM_WIDTH;
    localparam int PROD_D_W = GAIN_W + 1 + DERR_W;
    localparam int RAW_W    = PROD_I_W + 2;
    localparam int SHIFT_W  = RAW_W - DRIVE_SHIFT;

    localparam logic signed [CLAMP_W-1:0] SUM_MAX_C =
        CLAMP_W'({1'b0, {(SUM_WIDTH - 1){1'b1}}});
    localparam logic signed [CLAMP_W-1:0] SUM_MIN_C = -SUM_MAX_C - CLAMP_W'(1);

    localparam logic signed [SHIFT_W-1:0] OUT_MAX_S = SHIFT_W'(OUT_LIMIT);
    localparam logic signed [SHIFT_W-1:0] OUT_MIN_S = -OUT_MAX_S;

    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = DRIVE_W'(OUT_LIMIT);
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -DRIVE_MAX;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = LIMIT_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_SPEED   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_P         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_I         = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_D         = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_INTEGRAL_LIMIT = 3'd4;

    localparam logic signed [SPEED_W-1:0] TARGET_RESET = 16'sd0;
    localparam logic [GAIN_W-1:0]         GAIN_P_RESET = 16'd7680;
    localparam logic [GAIN_W-1:0]         GAIN_I_RESET = 16'd3840;
    localparam logic [GAIN_W-1:0]         GAIN_D_RESET = 16'd512;
    localparam logic [LIMIT_W-1:0]        LIMIT_RESET  = 23'd266;

    typedef struct packed {
        logic signed [SPEED_W-1:0] target_speed;
        logic [GAIN_W-1:0]         gain_p;
        logic [GAIN_W-1:0]         gain_i;
        logic [GAIN_W-1:0]         gain_d;
        logic [LIMIT_W-1:0]        integral_limit;
    } cfg_t;

    // Error terms handed from the error stage to the multiplier stage.
    typedef struct packed {
        logic signed [ERR_W-1:0]     err;
        logic signed [SUM_WIDTH-1:0] sum;
        logic signed [DERR_W-1:0]    derr;
    } err_terms_t;

    // Registered products handed to the output stage.
    typedef struct packed {
        logic signed [PROD_P_W-1:0] prod_p;
        logic signed [PROD_I_W-1:0] prod_i;
        logic signed [PROD_D_W-1:0] prod_d;
    } products_t;

endpackage

// File: src/pss_cfg_regs.sv
module pss_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [pss_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pss_pkg::CFG_DATA_W-1:0]    cfg_data,
    output pss_pkg::cfg_t                     cfg
);
    import pss_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_TARGET_SPEED:   cfg_next.target_speed   = $signed(cfg_data[SPEED_W-1:0]);
                CFG_GAIN_P:         cfg_next.gain_p         = cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:         cfg_next.gain_i         = cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:         cfg_next.gain_d         = cfg_data[GAIN_W-1:0];
                CFG_INTEGRAL_LIMIT: cfg_next.integral_limit = cfg_data[LIMIT_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_speed   <= TARGET_RESET;
            cfg_reg.gain_p         <= GAIN_P_RESET;
            cfg_reg.gain_i         <= GAIN_I_RESET;
            cfg_reg.gain_d         <= GAIN_D_RESET;
            cfg_reg.integral_limit <= LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/pss_err_stage.sv
module pss_err_stage (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pss_pkg::cfg_t                         cfg,
    input  logic                                  up_valid,
    output logic                                  up_ready,
    input  logic signed [pss_pkg::SPEED_W-1:0]    meas,
    output logic                                  valid,
    input  logic                                  down_ready,
    output pss_pkg::err_terms_t                   terms
);
    import pss_pkg::*;

    logic                        valid_reg;
    err_terms_t                  terms_reg;
    logic signed [SUM_WIDTH-1:0] error_sum_reg;
    logic signed [ERR_W-1:0]     prev_err_reg;

    logic signed [ERR_W-1:0]     err_next;
    logic signed [CLAMP_W-1:0]   sum_wide;
    logic signed [CLAMP_W-1:0]   lim_pos;
    logic signed [CLAMP_W-1:0]   lim_neg;
    logic signed [CLAMP_W-1:0]   sum_lim;
    logic signed [CLAMP_W-1:0]   sum_sat;
    logic signed [SUM_WIDTH-1:0] sum_next;
    logic signed [DERR_W-1:0]    derr_next;
    logic                        load;

    assign up_ready = !valid_reg || down_ready;
    assign load     = up_valid && up_ready;

    always_comb
    begin
        err_next = ERR_W'(cfg.target_speed) - ERR_W'(meas);
        sum_wide = CLAMP_W'(error_sum_reg) + CLAMP_W'(err_next);
        lim_pos  = CLAMP_W'($signed({1'b0, cfg.integral_limit}));
        lim_neg  = -lim_pos;

        // The integral limit only applies while a target is set.
        sum_lim = sum_wide;
        if (cfg.target_speed != '0)
        begin
            if (sum_wide > lim_pos)
                sum_lim = lim_pos;
            else if (sum_wide < lim_neg)
                sum_lim = lim_neg;
        end

        sum_sat = sum_lim;
        if (sum_lim > SUM_MAX_C)
            sum_sat = SUM_MAX_C;
        else if (sum_lim < SUM_MIN_C)
            sum_sat = SUM_MIN_C;

        sum_next  = sum_sat[SUM_WIDTH-1:0];
        derr_next = DERR_W'(err_next) - DERR_W'(prev_err_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            error_sum_reg <= '0;
            prev_err_reg  <= '0;
        end
        else
        begin
            if (up_ready)
                valid_reg <= up_valid;
            if (load)
            begin
                error_sum_reg <= sum_next;
                prev_err_reg  <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            terms_reg.err  <= err_next;
            terms_reg.sum  <= sum_next;
            terms_reg.derr <= derr_next;
        end
    end

    assign valid = valid_reg;
    assign terms = terms_reg;

endmodule

// File: src/pss_mul_stage.sv
module pss_mul_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pss_pkg::cfg_t         cfg,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  pss_pkg::err_terms_t   terms,
    output logic                  valid,
    input  logic                  down_ready,
    output pss_pkg::products_t    prods
);
    import pss_pkg::*;

    logic      valid_reg;
    products_t prods_reg;
    products_t prods_next;
    logic      load;

    assign up_ready = !valid_reg || down_ready;
    assign load     = up_valid && up_ready;

    // Gains are unsigned, so each gets a zero sign bit before the signed multiply.
    always_comb
    begin
        prods_next.prod_p = PROD_P_W'($signed({1'b0, cfg.gain_p})) * PROD_P_W'(terms.err);
        prods_next.prod_i = PROD_I_W'($signed({1'b0, cfg.gain_i})) * PROD_I_W'(terms.sum);
        prods_next.prod_d = PROD_D_W'($signed({1'b0, cfg.gain_d})) * PROD_D_W'(terms.derr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            prods_reg <= prods_next;
    end

    assign valid = valid_reg;
    assign prods = prods_reg;

endmodule

// File: src/pss_out_stage.sv
module pss_out_stage (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  up_valid,
    output logic                                  up_ready,
    input  pss_pkg::products_t                    prods,
    output logic                                  valid,
    input  logic                                  down_ready,
    output logic signed [pss_pkg::DRIVE_W-1:0]    drive,
    output logic                                  drive_saturated
);
    import pss_pkg::*;

    logic                      valid_reg;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic                      sat_reg;

    logic signed [RAW_W-1:0]   raw;
    logic signed [SHIFT_W-1:0] shifted;
    logic signed [SHIFT_W-1:0] clipped;
    logic                      sat_next;
    logic signed [DRIVE_W-1:0] drive_next;
    logic                      load;

    assign up_ready = !valid_reg || down_ready;
    assign load     = up_valid && up_ready;

    always_comb
    begin
        raw = RAW_W'(prods.prod_p) + RAW_W'(prods.prod_i) + RAW_W'(prods.prod_d);
        // Dropping the low bits of a two's complement value rounds toward minus infinity.
        shifted  = raw[RAW_W-1:DRIVE_SHIFT];
        clipped  = shifted;
        sat_next = 1'b0;
        if (shifted > OUT_MAX_S)
        begin
            clipped  = OUT_MAX_S;
            sat_next = 1'b1;
        end
        else if (shifted < OUT_MIN_S)
        begin
            clipped  = OUT_MIN_S;
            sat_next = 1'b1;
        end
        drive_next = clipped[DRIVE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            drive_reg <= drive_next;
            sat_reg   <= sat_next;
        end
    end

    assign valid           = valid_reg;
    assign drive           = drive_reg;
    assign drive_saturated = sat_reg;

endmodule

// File: src/pid_speed_step.sv
// Path: input register, error, multiplier, output stage. The error and running sum
// update together. Throughput: one item per cycle while in_stall is low.
// Reset (rst_n low, asynchronous) empties the pipeline and clears the error sum
// and the previous error; the registers return to target 0, gains 30.0, 15.0 and
// 2.0 and an integral limit of 266.
module pid_speed_step (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [pss_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [pss_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [pss_pkg::SPEED_W-1:0]    measured_speed,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [pss_pkg::DRIVE_W-1:0]    drive,
    output logic                                  drive_saturated
);
    import pss_pkg::*;

    // The datapath is a four-register pipeline:
    //   input register   - holds the accepted speed sample;
    //   error stage      - forms the error, updates the clamped error sum and the
    //                      previous error, and registers error, sum and error delta;
    //   multiplier stage - registers the three gain products;
    //   output stage     - adds, shifts by eight, clips to the output limit and holds
    //                      the finished item until it is taken.
    // Every stage loads whenever it is empty or its successor is taking its item, so
    // bubbles close up and a waiting result stalls the input only once all four
    // registers hold an item.
    // The controller state lives in the error stage and is touched only when an item
    // moves into it, which keeps items in strict order against that state.

    cfg_t                      cfg;
    logic                      in_valid_reg;
    logic signed [SPEED_W-1:0] meas_reg;
    logic                      in_ready;
    logic                      in_load;

    logic                      err_up_ready;
    logic                      err_valid;
    err_terms_t                err_terms;

    logic                      mul_up_ready;
    logic                      mul_valid;
    products_t                 mul_prods;

    logic                      out_up_ready;

    pss_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register: the sample is captured as it is accepted.
    assign in_ready = !in_valid_reg || err_up_ready;
    assign in_load  = in_valid && in_ready;
    assign in_stall = !in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
            meas_reg <= measured_speed;
    end

    pss_err_stage u_err (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .up_valid   (in_valid_reg),
        .up_ready   (err_up_ready),
        .meas       (meas_reg),
        .valid      (err_valid),
        .down_ready (mul_up_ready),
        .terms      (err_terms)
    );

    pss_mul_stage u_mul (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .up_valid   (err_valid),
        .up_ready   (mul_up_ready),
        .terms      (err_terms),
        .valid      (mul_valid),
        .down_ready (out_up_ready),
        .prods      (mul_prods)
    );

    pss_out_stage u_out (
        .clk             (clk),
        .rst_n           (rst_n),
        .up_valid        (mul_valid),
        .up_ready        (out_up_ready),
        .prods           (mul_prods),
        .valid           (out_valid),
        .down_ready      (!out_stall),
        .drive           (drive),
        .drive_saturated (drive_saturated)
    );

endmodule

// File: src/pss_checker.sv
`include "pid_speed_step_assert.svh"

module pss_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_stall,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic signed [pss_pkg::DRIVE_W-1:0]    drive,
    input  logic                                  drive_saturated
);
    import pss_pkg::*;

    `PSS_ASSERT_NOW(a_drive_range, out_valid,
        (drive <= DRIVE_MAX) && (drive >= DRIVE_MIN), "drive beyond output limit")

    `PSS_ASSERT_NOW(a_sat_at_limit, out_valid && drive_saturated,
        (drive == DRIVE_MAX) || (drive == DRIVE_MIN), "saturated drive not at limit")

    `PSS_ASSERT_NOW(a_no_back_stall, !out_stall, !in_stall,
        "input stalled while output side is free")

    `PSS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(drive) && $stable(drive_saturated), "stalled result changed")

endmodule

bind pid_speed_step pss_checker u_pss_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .drive           (drive),
    .drive_saturated (drive_saturated)
);
